// ===== hw/rtl/rmft_pkg.sv =====
// Shared types and constants for the range-match flow table.
// Used by rmft_rule_mem, rmft_match_unit and range_match_flow_table.
`timescale 1ns / 1ps

package rmft_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ADDRESS_BITS  = 10;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int HIT_W = 32;
    localparam int PORT_W = 4;
    localparam int SEL_W  = 4;
    localparam int KIND_W = 3;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_RELAY  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOCAL  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STORED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FULL   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd5;

    typedef struct packed {
        logic [ADDRESS_BITS-1:0] low;
        logic [ADDRESS_BITS-1:0] high;
        logic                    fwd;
        logic [PORT_W-1:0]       port;
        logic [HIT_W-1:0]        hits;
    } rule_t;

    typedef struct packed {
        logic             en;
        logic             all;   // write every field, else only the hit count
        logic [IDX_W-1:0] addr;
        rule_t            rule;
    } mem_wr_t;

    typedef struct packed {
        logic             hit;
        logic             relay;
        logic [HIT_W-1:0] hits_inc;
    } match_t;

endpackage

// ===== hw/rtl/rmft_rule_mem.sv =====
// Rule storage: one write port and one read port with registered read data.
// Depends on rmft_pkg for the rule record and write request types.
`timescale 1ns / 1ps

module rmft_rule_mem
    import rmft_pkg::*;
(
    input  logic             aclk,
    input  mem_wr_t          wr,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output rule_t            rd_data
);

    logic [ADDRESS_BITS-1:0] low_mem  [TABLE_ENTRIES];
    logic [ADDRESS_BITS-1:0] high_mem [TABLE_ENTRIES];
    logic                    fwd_mem  [TABLE_ENTRIES];
    logic [PORT_W-1:0]       port_mem [TABLE_ENTRIES];
    logic [HIT_W-1:0]        hits_mem [TABLE_ENTRIES];

    rule_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            hits_mem[wr.addr] <= wr.rule.hits;
            if (wr.all) begin
                low_mem[wr.addr]  <= wr.rule.low;
                high_mem[wr.addr] <= wr.rule.high;
                fwd_mem[wr.addr]  <= wr.rule.fwd;
                port_mem[wr.addr] <= wr.rule.port;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg.low  <= low_mem[rd_addr];
            rd_data_reg.high <= high_mem[rd_addr];
            rd_data_reg.fwd  <= fwd_mem[rd_addr];
            rd_data_reg.port <= port_mem[rd_addr];
            rd_data_reg.hits <= hits_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/rmft_match_unit.sv =====
// Shared range compare and hit-count increment, used once per scanned rule.
// Depends on rmft_pkg for the rule record and match result types.
`timescale 1ns / 1ps

module rmft_match_unit
    import rmft_pkg::*;
(
    input  logic [ADDRESS_BITS-1:0] dest,
    input  rule_t                   rule,
    input  logic                    slot_zero,
    output match_t                  result
);

    always_comb begin
        result.hit      = (dest >= rule.low) && (dest <= rule.high);
        // A forwarding rule in the first slot counts as a match but never relays.
        result.relay    = result.hit && rule.fwd && !slot_zero;
        result.hits_inc = rule.hits + HIT_W'(1);
    end

endmodule

// ===== hw/rtl/range_match_flow_table.sv =====
// Top level of the range-match flow table: sequencer, rule count and output word.
// Depends on rmft_pkg, rmft_rule_mem and rmft_match_unit.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | op, dest_ip, range_low/high, forward_action,
//          |           |                      | port_in, initial_count, entry_select
//  m_      | out       | m_valid / m_ready    | result_kind, port_out, match_low/high, hit_count
//
// A lookup scans n rules, n at most TABLE_ENTRIES: one rule per cycle passes
// the single rule memory read port and the shared compare unit. An add goes
// straight from idle to the push step, a count read through a read step first.
// Reset clears the rule count and the sequencer; rule contents are not cleared.
// The result word sits in an output register; a stalled m_ready holds the
// sequencer in its push step, and a new word is accepted once it is idle.
`timescale 1ns / 1ps

module range_match_flow_table
    import rmft_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_op,
    input  logic [ADDRESS_BITS-1:0] s_dest_ip,
    input  logic [ADDRESS_BITS-1:0] s_range_low,
    input  logic [ADDRESS_BITS-1:0] s_range_high,
    input  logic                    s_forward_action,
    input  logic [PORT_W-1:0]       s_port_in,
    input  logic [HIT_W-1:0]        s_initial_count,
    input  logic [SEL_W-1:0]        s_entry_select,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [KIND_W-1:0]       m_result_kind,
    output logic [PORT_W-1:0]       m_port_out,
    output logic [ADDRESS_BITS-1:0] m_match_low,
    output logic [ADDRESS_BITS-1:0] m_match_high,
    output logic [HIT_W-1:0]        m_hit_count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        used_reg, used_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    matched_reg, matched_next;
    logic [ADDRESS_BITS-1:0] dest_reg, dest_next;

    // Pending result word, moved to the output register in the push step.
    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic [PORT_W-1:0]       port_reg, port_next;
    logic [ADDRESS_BITS-1:0] low_reg, low_next;
    logic [ADDRESS_BITS-1:0] high_reg, high_next;
    logic [HIT_W-1:0]        hits_reg, hits_next;

    logic                    m_valid_reg;
    logic [KIND_W-1:0]       m_kind_reg;
    logic [PORT_W-1:0]       m_port_reg;
    logic [ADDRESS_BITS-1:0] m_low_reg, m_high_reg;
    logic [HIT_W-1:0]        m_hits_reg;

    mem_wr_t          mem_wr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    rule_t            rd_rule;
    match_t           match;
    logic             accept;
    logic             out_free;
    logic             last_rule;

    rmft_rule_mem u_mem (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_rule)
    );

    rmft_match_unit u_match (
        .dest      (dest_reg),
        .rule      (rd_rule),
        .slot_zero (idx_reg == '0),
        .result    (match)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_rule = ((CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(used_reg);

    always_comb begin
        state_next   = state_reg;
        used_next    = used_reg;
        idx_next     = idx_reg;
        matched_next = matched_reg;
        dest_next    = dest_reg;
        kind_next    = kind_reg;
        port_next    = port_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        hits_next    = hits_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        mem_wr       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    dest_next = s_dest_ip;
                    port_next = '0;
                    low_next  = '0;
                    high_next = '0;
                    hits_next = '0;
                    case (s_op)
                        OP_LOOKUP: begin
                            matched_next = 1'b0;
                            if (used_reg == '0) begin
                                kind_next  = KIND_QUERY;
                                state_next = ST_PUSH;
                            end else begin
                                idx_next   = '0;
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_ADD: begin
                            if (32'(used_reg) >= TABLE_ENTRIES) begin
                                kind_next = KIND_FULL;
                            end else begin
                                mem_wr.en        = 1'b1;
                                mem_wr.all       = 1'b1;
                                mem_wr.addr      = IDX_W'(used_reg);
                                mem_wr.rule.low  = s_range_low;
                                mem_wr.rule.high = s_range_high;
                                mem_wr.rule.fwd  = s_forward_action;
                                mem_wr.rule.port = s_port_in;
                                mem_wr.rule.hits = s_initial_count;
                                used_next        = used_reg + CNT_W'(1);
                                kind_next        = KIND_STORED;
                            end
                            state_next = ST_PUSH;
                        end
                        OP_READ: begin
                            kind_next = KIND_READ;
                            if (32'(s_entry_select) < TABLE_ENTRIES) begin
                                rd_en      = 1'b1;
                                rd_addr    = IDX_W'(s_entry_select);
                                state_next = ST_READ;
                            end else begin
                                state_next = ST_PUSH;
                            end
                        end
                        default: begin
                            // Undefined op: the word is consumed without a result.
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (match.hit) begin
                    mem_wr.en        = 1'b1;
                    mem_wr.addr      = idx_reg;
                    mem_wr.rule.hits = match.hits_inc;
                end
                if (match.relay) begin
                    kind_next  = KIND_RELAY;
                    port_next  = rd_rule.port;
                    low_next   = rd_rule.low;
                    high_next  = rd_rule.high;
                    state_next = ST_PUSH;
                end else if (last_rule) begin
                    kind_next  = (matched_reg || match.hit) ? KIND_LOCAL : KIND_QUERY;
                    state_next = ST_PUSH;
                end else begin
                    matched_next = matched_reg || match.hit;
                    idx_next     = idx_reg + IDX_W'(1);
                    rd_en        = 1'b1;
                    rd_addr      = idx_reg + IDX_W'(1);
                end
            end
            ST_READ: begin
                hits_next  = rd_rule.hits;
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (state_reg == ST_PUSH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        matched_reg <= matched_next;
        dest_reg    <= dest_next;
        kind_reg    <= kind_next;
        port_reg    <= port_next;
        low_reg     <= low_next;
        high_reg    <= high_next;
        hits_reg    <= hits_next;
        if (state_reg == ST_PUSH && out_free) begin
            m_kind_reg <= kind_reg;
            m_port_reg <= port_reg;
            m_low_reg  <= low_reg;
            m_high_reg <= high_reg;
            m_hits_reg <= hits_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_port_out    = m_port_reg;
    assign m_match_low   = m_low_reg;
    assign m_match_high  = m_high_reg;
    assign m_hit_count   = m_hits_reg;

    // The rule count never runs past the table size.
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(used_reg) <= TABLE_ENTRIES)
        else $error("rule count beyond table size");

    // The count only grows, by one, after an add word taken in idle.
    a_used_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_reg != $past(used_reg)) |->
            (used_reg == $past(used_reg) + CNT_W'(1)) && $past(accept)
            && ($past(s_op) == OP_ADD))
        else $error("rule count changed without an add");

    // The scan index always points at a stored rule.
    a_scan_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (CNT_W'(idx_reg) < used_reg))
        else $error("scan index beyond stored rules");

    // A new output word is loaded only from the push step.
    a_push_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_PUSH))
        else $error("output word loaded outside push step");

endmodule
